FILE: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, types and helpers of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_BITS = 12;
  localparam int TOP_ORDER = 10;
  localparam int EFF_TOP   = (TOP_ORDER < PAGE_BITS) ? TOP_ORDER : PAGE_BITS;
  localparam int NPAGES    = 1 << PAGE_BITS;
  localparam int ORDERS    = EFF_TOP + 1;

  localparam int ORD_W     = 4;
  localparam int CNT_W     = 13;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;

  // free map: one bit per aligned block per order, orders packed upward
  localparam int POS_W     = PAGE_BITS + 1;
  localparam int WORD_W    = 64;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int ADDR_W    = POS_W - BIT_W;
  localparam int MAP_WORDS = 1 << ADDR_W;

  localparam logic [POS_W:0] SPAN = (POS_W + 1)'(2 * NPAGES);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_ADD     = 2'd2,
    OP_RESERVE = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOMEM = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC_INIT,
    S_SCAN_INIT,
    S_FIND_RD,
    S_FIND_CHK,
    S_NEXT_K,
    S_SPLIT,
    S_RS_LEFT,
    S_RS_RIGHT,
    S_RS_RESUME,
    S_MERGE,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_AR_STEP,
    S_SET_RD,
    S_SET_WR,
    S_DONE
  } bpa_state_t;

  typedef struct packed {
    logic              rd;
    logic [ADDR_W-1:0] raddr;
    logic              wr;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
  } map_req_t;

  // first map position of the blocks of order k
  function automatic logic [POS_W-1:0] base_pos(input logic [ORD_W-1:0] k);
    logic [POS_W:0] part;
    begin
      part = SPAN >> k;
      return POS_W'(SPAN - part);
    end
  endfunction

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    begin
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
        if (w[i]) idx = BIT_W'(i);
      end
      return idx;
    end
  endfunction

endpackage

FILE: hw/rtl/bpa_req_if.sv
// ----------------------------------------------------------------------------
// bpa_req_if
// Request channel: operation, order, first page and page count.
// ----------------------------------------------------------------------------
interface bpa_req_if import bpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [ORD_W-1:0]     order;
  logic [PAGE_BITS-1:0] page;
  logic [CNT_W-1:0]     count;

  modport source (output valid, output op, output order, output page, output count,
                  input ready);
  modport sink   (input valid, input op, input order, input page, input count,
                  output ready);
endinterface

FILE: hw/rtl/bpa_rsp_if.sv
// ----------------------------------------------------------------------------
// bpa_rsp_if
// Response channel: status and allocated page.
// ----------------------------------------------------------------------------
interface bpa_rsp_if import bpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [PAGE_BITS-1:0] page_res;

  modport source (output valid, output status, output page_res, input ready);
  modport sink   (input valid, input status, input page_res, output ready);
endinterface

FILE: hw/rtl/bpa_map.sv
// ----------------------------------------------------------------------------
// bpa_map
// Free map memory, one read and one write port, registered read data.
// Words never written since reset read as zero.
// ----------------------------------------------------------------------------
module bpa_map import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  map_req_t          mreq,
  output logic [WORD_W-1:0] mdata
);

  logic [WORD_W-1:0]    mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] wvalid;
  logic [WORD_W-1:0]    rdata;
  logic                 rvalid;

  always_ff @(posedge clk) begin
    if (mreq.wr) mem[mreq.waddr] <= mreq.wdata;
    if (mreq.rd) rdata <= mem[mreq.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
      rvalid <= 1'b0;
    end else begin
      if (mreq.wr) wvalid[mreq.waddr] <= 1'b1;
      if (mreq.rd) rvalid <= wvalid[mreq.raddr];
    end
  end

  assign mdata = rvalid ? rdata : '0;

endmodule

FILE: hw/rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: request checks, map scans, split, merge, range add and
// reserve, per-order free counts and the response register.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  bpa_req_if.sink           req,
  bpa_rsp_if.source         rsp,
  output map_req_t          mreq,
  input  logic [WORD_W-1:0] mdata
);

  bpa_state_t state, state_next;

  op_t                  op_r;
  logic [ORD_W-1:0]     ord_r;
  logic [PAGE_BITS-1:0] pg_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [POS_W-1:0]     end_r, end_next;
  logic [POS_W-1:0]     last_r, last_next;
  logic [ORD_W-1:0]     k, k_next;
  logic [POS_W-1:0]     cur, cur_next;
  logic [POS_W-1:0]     hi, hi_next;
  logic [POS_W-1:0]     fpos, fpos_next;
  logic [POS_W-1:0]     p, p_next;
  logic [POS_W-1:0]     bpos, bpos_next;
  logic [ORD_W-1:0]     bord, bord_next;
  logic [POS_W-1:0]     ar_start, ar_start_next;
  logic [POS_W-1:0]     ar_len, ar_len_next;
  logic                 ar_second, ar_second_next;
  logic                 chk_phase, chk_phase_next;
  status_t              status_r, status_next;
  logic [PAGE_BITS-1:0] res_r, res_next;
  logic [CNT_W-1:0]     free_cnt [ORDERS];

  logic                 out_valid;
  logic [STAT_W-1:0]    out_status;
  logic [PAGE_BITS-1:0] out_page;
  logic                 out_load;

  logic                 inc_en, dec_en;
  logic [ORD_W-1:0]     inc_idx, dec_idx;

  // shared datapath terms
  logic [POS_W-1:0]  pg13, base_k, base_km1, base_ar, scan_lo, scan_hi;
  logic [ORD_W-1:0]  km1, pick, ar_k;
  logic              pick_any;
  logic              same_word, hit, bbit;
  logic [WORD_W-1:0] lmask, hmask, masked;
  logic [BIT_W-1:0]  hit_idx;
  logic [POS_W-1:0]  hit_pos, hit_page, be;
  logic [POS_W:0]    range_sum;
  logic              accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  assign pg13      = {1'b0, pg_r};
  assign km1       = k - ORD_W'(1);
  assign base_k    = base_pos(k);
  assign base_km1  = base_pos(km1);
  assign scan_lo   = base_k + (pg13 >> k);
  assign scan_hi   = base_k + (last_r >> k);
  assign range_sum = {2'b00, pg_r} + {1'b0, cnt_r};
  assign be        = p + (POS_W'(1) << k);

  assign same_word = (cur[POS_W-1:BIT_W] == hi[POS_W-1:BIT_W]);
  assign lmask     = {WORD_W{1'b1}} << cur[BIT_W-1:0];
  assign hmask     = same_word ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi[BIT_W-1:0]))
                               : {WORD_W{1'b1}};
  assign masked    = mdata & lmask & hmask;
  assign hit       = |masked;
  assign hit_idx   = lowest_set(masked);
  assign hit_pos   = {cur[POS_W-1:BIT_W], hit_idx};
  assign hit_page  = (hit_pos - base_k) << k;
  assign bbit      = mdata[bpos[BIT_W-1:0]];
  assign base_ar   = base_pos(ar_k);

  always_comb begin
    pick     = '0;
    pick_any = 1'b0;
    for (int i = EFF_TOP; i >= 0; i--) begin
      if (ORD_W'(i) >= ord_r && free_cnt[i] != '0) begin
        pick     = ORD_W'(i);
        pick_any = 1'b1;
      end
    end
  end

  always_comb begin
    ar_k = '0;
    for (int i = 0; i <= EFF_TOP; i++) begin
      if ((ar_start & ((POS_W'(1) << i) - POS_W'(1))) == '0 &&
          (POS_W'(1) << i) <= ar_len) ar_k = ORD_W'(i);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_CHECK;
      end
      S_CHECK: begin
        case (op_r)
          OP_ALLOC: begin
            if (ord_r > ORD_W'(EFF_TOP) || !pick_any) state_next = S_DONE;
            else state_next = S_ALLOC_INIT;
          end
          OP_FREE: begin
            if (ord_r > ORD_W'(EFF_TOP) ||
                (pg13 & ((POS_W'(1) << ord_r) - POS_W'(1))) != '0) state_next = S_DONE;
            else state_next = S_SCAN_INIT;
          end
          default: begin
            if (range_sum > (POS_W + 1)'(NPAGES) || cnt_r == '0) state_next = S_DONE;
            else state_next = S_SCAN_INIT;
          end
        endcase
      end
      S_ALLOC_INIT: state_next = S_FIND_RD;
      S_SCAN_INIT:  state_next = S_FIND_RD;
      S_FIND_RD:    state_next = S_FIND_CHK;
      S_FIND_CHK: begin
        if (hit) begin
          if (chk_phase) state_next = S_DONE;
          else if (op_r == OP_ALLOC) state_next = S_SPLIT;
          else state_next = S_RS_LEFT;
        end else if (same_word) begin
          state_next = S_NEXT_K;
        end else begin
          state_next = S_FIND_RD;
        end
      end
      S_NEXT_K: begin
        if (k == ORD_W'(EFF_TOP)) begin
          if (!chk_phase) state_next = S_DONE;
          else if (op_r == OP_FREE) state_next = S_MERGE;
          else state_next = S_AR_STEP;
        end else begin
          state_next = S_SCAN_INIT;
        end
      end
      S_SPLIT: begin
        if (k > ord_r) state_next = S_SET_RD;
        else state_next = S_DONE;
      end
      S_RS_LEFT: begin
        if (p < pg13) state_next = S_AR_STEP;
        else state_next = S_RS_RIGHT;
      end
      S_RS_RIGHT: begin
        if (end_r < be) state_next = S_AR_STEP;
        else state_next = S_RS_RESUME;
      end
      S_RS_RESUME: begin
        if (fpos >= hi) state_next = S_NEXT_K;
        else state_next = S_FIND_RD;
      end
      S_MERGE: begin
        if (k < ORD_W'(EFF_TOP)) state_next = S_MERGE_RD;
        else state_next = S_SET_RD;
      end
      S_MERGE_RD: state_next = S_MERGE_CHK;
      S_MERGE_CHK: begin
        if (bbit) state_next = S_MERGE;
        else state_next = S_SET_RD;
      end
      S_AR_STEP: begin
        if (ar_len != '0) state_next = S_SET_RD;
        else if (op_r == OP_ADD) state_next = S_DONE;
        else if (!ar_second) state_next = S_RS_RIGHT;
        else state_next = S_RS_RESUME;
      end
      S_SET_RD: state_next = S_SET_WR;
      S_SET_WR: begin
        if (op_r == OP_ALLOC) state_next = S_SPLIT;
        else if (op_r == OP_FREE) state_next = S_DONE;
        else state_next = S_AR_STEP;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and map access
  always_comb begin
    end_next       = end_r;
    last_next      = last_r;
    k_next         = k;
    cur_next       = cur;
    hi_next        = hi;
    fpos_next      = fpos;
    p_next         = p;
    bpos_next      = bpos;
    bord_next      = bord;
    ar_start_next  = ar_start;
    ar_len_next    = ar_len;
    ar_second_next = ar_second;
    chk_phase_next = chk_phase;
    status_next    = status_r;
    res_next       = res_r;
    inc_en         = 1'b0;
    inc_idx        = bord;
    dec_en         = 1'b0;
    dec_idx        = k;
    out_load       = 1'b0;
    mreq           = '0;
    case (state)
      S_IDLE: begin
        status_next = ST_OK;
        res_next    = '0;
      end
      S_CHECK: begin
        k_next = '0;
        case (op_r)
          OP_ALLOC: begin
            chk_phase_next = 1'b0;
            k_next         = pick;
            if (ord_r > ORD_W'(EFF_TOP)) status_next = ST_BAD;
            else if (!pick_any) status_next = ST_NOMEM;
          end
          OP_FREE: begin
            chk_phase_next = 1'b1;
            last_next      = pg13 + (POS_W'(1) << ord_r) - POS_W'(1);
            if (ord_r > ORD_W'(EFF_TOP) ||
                (pg13 & ((POS_W'(1) << ord_r) - POS_W'(1))) != '0) status_next = ST_BAD;
          end
          default: begin
            chk_phase_next = (op_r == OP_ADD);
            end_next       = POS_W'(range_sum);
            last_next      = POS_W'(range_sum) - POS_W'(1);
            if (range_sum > (POS_W + 1)'(NPAGES)) status_next = ST_BAD;
          end
        endcase
      end
      S_ALLOC_INIT: begin
        cur_next = base_k;
        hi_next  = base_k + (POS_W'(NPAGES) >> k) - POS_W'(1);
      end
      S_SCAN_INIT: begin
        cur_next = scan_lo;
        hi_next  = scan_hi;
      end
      S_FIND_RD: begin
        mreq.rd    = 1'b1;
        mreq.raddr = cur[POS_W-1:BIT_W];
      end
      S_FIND_CHK: begin
        if (hit) begin
          if (chk_phase) begin
            status_next = ST_BAD;
          end else begin
            mreq.wr    = 1'b1;
            mreq.waddr = cur[POS_W-1:BIT_W];
            mreq.wdata = mdata & ~({{(WORD_W-1){1'b0}}, 1'b1} << hit_idx);
            dec_en     = 1'b1;
            fpos_next  = hit_pos;
            p_next     = hit_page;
            if (op_r == OP_ALLOC) res_next = hit_page[PAGE_BITS-1:0];
          end
        end else if (!same_word) begin
          cur_next = {cur[POS_W-1:BIT_W] + ADDR_W'(1), {BIT_W{1'b0}}};
        end
      end
      S_NEXT_K: begin
        if (k == ORD_W'(EFF_TOP)) begin
          chk_phase_next = 1'b0;
          k_next         = ord_r;
          p_next         = pg13;
          ar_start_next  = pg13;
          ar_len_next    = cnt_r;
        end else begin
          k_next = k + ORD_W'(1);
        end
      end
      S_SPLIT: begin
        if (k > ord_r) begin
          k_next    = km1;
          bord_next = km1;
          bpos_next = base_km1 + ((p >> km1) | POS_W'(1));
        end
      end
      S_RS_LEFT: begin
        ar_start_next  = p;
        ar_len_next    = pg13 - p;
        ar_second_next = 1'b0;
      end
      S_RS_RIGHT: begin
        ar_start_next  = end_r;
        ar_len_next    = be - end_r;
        ar_second_next = 1'b1;
      end
      S_RS_RESUME: begin
        cur_next = fpos + POS_W'(1);
      end
      S_MERGE: begin
        if (k < ORD_W'(EFF_TOP)) begin
          bpos_next = base_k + ((p >> k) ^ POS_W'(1));
        end else begin
          bpos_next = base_k + (p >> k);
          bord_next = k;
        end
      end
      S_MERGE_RD: begin
        mreq.rd    = 1'b1;
        mreq.raddr = bpos[POS_W-1:BIT_W];
      end
      S_MERGE_CHK: begin
        if (bbit) begin
          mreq.wr    = 1'b1;
          mreq.waddr = bpos[POS_W-1:BIT_W];
          mreq.wdata = mdata & ~({{(WORD_W-1){1'b0}}, 1'b1} << bpos[BIT_W-1:0]);
          dec_en     = 1'b1;
          p_next     = p & ~(POS_W'(1) << k);
          k_next     = k + ORD_W'(1);
        end else begin
          bpos_next = base_k + (p >> k);
          bord_next = k;
        end
      end
      S_AR_STEP: begin
        if (ar_len != '0) begin
          bpos_next     = base_ar + (ar_start >> ar_k);
          bord_next     = ar_k;
          ar_start_next = ar_start + (POS_W'(1) << ar_k);
          ar_len_next   = ar_len - (POS_W'(1) << ar_k);
        end
      end
      S_SET_RD: begin
        mreq.rd    = 1'b1;
        mreq.raddr = bpos[POS_W-1:BIT_W];
      end
      S_SET_WR: begin
        if (!bbit) begin
          mreq.wr    = 1'b1;
          mreq.waddr = bpos[POS_W-1:BIT_W];
          mreq.wdata = mdata | ({{(WORD_W-1){1'b0}}, 1'b1} << bpos[BIT_W-1:0]);
          inc_en     = 1'b1;
        end
      end
      S_DONE: begin
        out_load = !out_valid || rsp.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      chk_phase <= 1'b0;
      ar_second <= 1'b0;
      for (int i = 0; i < ORDERS; i++) free_cnt[i] <= '0;
    end else begin
      state     <= state_next;
      chk_phase <= chk_phase_next;
      ar_second <= ar_second_next;
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      for (int i = 0; i < ORDERS; i++) begin
        if (inc_en && inc_idx == ORD_W'(i)) free_cnt[i] <= free_cnt[i] + CNT_W'(1);
        else if (dec_en && dec_idx == ORD_W'(i)) free_cnt[i] <= free_cnt[i] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(req.op);
      ord_r <= req.order;
      pg_r  <= req.page;
      cnt_r <= req.count;
    end
    end_r    <= end_next;
    last_r   <= last_next;
    k        <= k_next;
    cur      <= cur_next;
    hi       <= hi_next;
    fpos     <= fpos_next;
    p        <= p_next;
    bpos     <= bpos_next;
    bord     <= bord_next;
    ar_start <= ar_start_next;
    ar_len   <= ar_len_next;
    status_r <= status_next;
    res_r    <= res_next;
    if (out_load) begin
      out_status <= status_r;
      out_page   <= res_r;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.page_res = out_page;

`ifndef SYNTHESIS
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(mreq.rd && mreq.wr))
    else $error("map read and write in one cycle");

  a_rd_then_use: assert property (@(posedge clk) disable iff (rst)
    mreq.rd |=> (state == S_FIND_CHK || state == S_MERGE_CHK || state == S_SET_WR))
    else $error("map read data not consumed");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mreq.wr)
    else $error("map written outside an operation");

  a_load_then_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (rsp.valid && rsp.status == $past(status_r)))
    else $error("response beat not loaded");
`endif

endmodule

FILE: hw/rtl/buddy_page_allocator_top.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// Buddy page allocator over 4096 pages, orders 0 to 10, free map in memory.
//
// req carries one beat per operation: allocate, free block, add free range
// or reserve range (op, order, page, count). rsp returns one beat per
// request: status and the allocated page (zero unless an allocate succeeds).
// One request is worked on at a time; req.ready is high while the sequencer
// waits for work, also while an earlier response beat waits on rsp.
// The single read port of the free map sets the pace: every map word scanned
// and every bit set takes a read, then a modify and write back. Allocate
// scans for a free block and then splits it; free checks every order for an
// overlapping free block, and range operations also scan every order.
// Reset empties the map at once through per-word valid bits: nothing free.
// When rsp stalls, the finished beat holds in the response register and
// the next request may be taken; its result waits until that beat leaves.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top import bpa_pkg::*; (
  input logic       clk,
  input logic       rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp
);

  map_req_t          mreq;
  logic [WORD_W-1:0] mdata;

  bpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .mreq  (mreq),
    .mdata (mdata)
  );

  bpa_map u_map (
    .clk   (clk),
    .rst   (rst),
    .mreq  (mreq),
    .mdata (mdata)
  );

endmodule

FILE: dv/buddy_page_allocator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_top_test
// Checks allocate, free, add range and reserve range against a bitmap
// predictor of the buddy free map. Directed requests cover the field limits
// and all rejections but an add over free pages; random traffic allocates,
// frees live blocks, reserves and adds ranges, with stalls on both channels.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top_test;
  import bpa_pkg::*;

  typedef struct {
    op_t                  op;
    logic [ORD_W-1:0]     order;
    logic [PAGE_BITS-1:0] page;
    logic [CNT_W-1:0]     count;
  } alloc_req_t;

  typedef struct {
    status_t              status;
    logic [PAGE_BITS-1:0] page;
    op_t                  op;
    logic [ORD_W-1:0]     order;
  } alloc_rsp_t;

  typedef struct {
    logic [PAGE_BITS-1:0] page;
    logic [ORD_W-1:0]     order;
  } block_t;

  logic clk;
  logic rst;

  bpa_req_if req ();
  bpa_rsp_if rsp ();

  buddy_page_allocator_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  alloc_req_t pend_q[$];
  alloc_rsp_t want_q[$];
  block_t     live_q[$];

  // free bit per order, indexed by block number
  bit free_bit [0:EFF_TOP][0:NPAGES-1];
  int free_cnt [0:EFF_TOP];

  int  errors;
  int  n_ok_alloc, n_nomem, n_bad, n_beats;
  bit  calm;
  int  req_gap, rsp_gap;

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  function automatic bit blk_free(int k, int p);
    return free_bit[k][p >> k];
  endfunction

  function automatic void blk_set(int k, int p);
    if (!free_bit[k][p >> k]) begin
      free_bit[k][p >> k] = 1'b1;
      free_cnt[k]++;
    end
  endfunction

  function automatic void blk_clr(int k, int p);
    if (free_bit[k][p >> k]) begin
      free_bit[k][p >> k] = 1'b0;
      free_cnt[k]--;
    end
  endfunction

  function automatic bit span_has_free(int start, int len);
    for (int k = 0; k <= EFF_TOP; k++) begin
      for (int i = start >> k; i <= (start + len - 1) >> k; i++) begin
        if (free_bit[k][i]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void span_mark(int start, int len);
    int k;
    while (len > 0) begin
      k = EFF_TOP;
      while (k > 0 && ((start % (1 << k)) != 0 || (1 << k) > len)) k--;
      blk_set(k, start);
      start += 1 << k;
      len -= 1 << k;
    end
  endfunction

  function automatic alloc_rsp_t predict_alloc(alloc_req_t r);
    alloc_rsp_t o;
    int         ord, pg, cnt, p, j, e, b, be;
    bit         found;
    o.status = ST_OK;
    o.page   = '0;
    o.op     = r.op;
    o.order  = r.order;
    ord = r.order;
    pg  = r.page;
    cnt = r.count;
    case (r.op)
      OP_ALLOC: begin
        if (ord > EFF_TOP) begin
          o.status = ST_BAD;
        end else begin
          o.status = ST_NOMEM;
          found = 1'b0;
          for (int k = ord; k <= EFF_TOP && !found; k++) begin
            if (free_cnt[k] == 0) continue;
            for (int i = 0; i < (NPAGES >> k) && !found; i++) begin
              if (free_bit[k][i]) begin
                p = i << k;
                blk_clr(k, p);
                j = k;
                while (j > ord) begin
                  j--;
                  blk_set(j, p + (1 << j));
                end
                o.page   = PAGE_BITS'(p);
                o.status = ST_OK;
                found    = 1'b1;
              end
            end
          end
        end
      end
      OP_FREE: begin
        if (ord > EFF_TOP || (pg % (1 << ord)) != 0 || span_has_free(pg, 1 << ord)) begin
          o.status = ST_BAD;
        end else begin
          j = ord;
          p = pg;
          while (j < EFF_TOP && blk_free(j, p ^ (1 << j))) begin
            blk_clr(j, p ^ (1 << j));
            p = p & ~(1 << j);
            j++;
          end
          blk_set(j, p);
        end
      end
      default: begin
        if (pg + cnt > NPAGES) begin
          o.status = ST_BAD;
        end else if (cnt == 0) begin
          o.status = ST_OK;
        end else if (r.op == OP_ADD) begin
          if (span_has_free(pg, cnt)) o.status = ST_BAD;
          else span_mark(pg, cnt);
        end else begin
          e = pg + cnt;
          for (int k = 0; k <= EFF_TOP; k++) begin
            for (int i = pg >> k; i <= (e - 1) >> k; i++) begin
              b  = i << k;
              be = b + (1 << k);
              if (!free_bit[k][i]) continue;
              blk_clr(k, b);
              if (b < pg) span_mark(b, pg - b);
              if (e < be) span_mark(e, be - e);
            end
          end
        end
      end
    endcase
    return o;
  endfunction

  task automatic push_req(op_t op, int ord, int pg, int cnt);
    alloc_req_t r;
    r.op    = op;
    r.order = ORD_W'(ord);
    r.page  = PAGE_BITS'(pg);
    r.count = CNT_W'(cnt);
    pend_q.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pend_q.size() != 0 || req.valid || want_q.size() != 0) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    alloc_req_t cur;
    bit         nv;
    if (rst) begin
      req.valid <= 1'b0;
      req_gap   <= 0;
    end else begin
      nv = req.valid;
      if (req.valid && req.ready) begin
        cur.op    = op_t'(req.op);
        cur.order = req.order;
        cur.page  = req.page;
        cur.count = req.count;
        want_q.push_back(predict_alloc(cur));
        nv = 1'b0;
      end
      if (!nv) begin
        if (req_gap > 0) begin
          req_gap <= req_gap - 1;
        end else if (pend_q.size() != 0) begin
          cur       = pend_q.pop_front();
          req.op    <= cur.op;
          req.order <= cur.order;
          req.page  <= cur.page;
          req.count <= cur.count;
          nv = 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) req_gap <= $urandom_range(1, 18);
        end
      end
      req.valid <= nv;
    end
  end

  // monitor
  always @(posedge clk) begin
    alloc_rsp_t w;
    block_t     blk;
    if (rst) begin
      rsp.ready <= 1'b0;
      rsp_gap   <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        n_beats++;
        if (want_q.size() == 0) begin
          $display("%0t: unexpected beat status %0d page %0d", $time, rsp.status,
                   rsp.page_res);
          errors++;
        end else begin
          w = want_q.pop_front();
          if (rsp.status !== w.status || rsp.page_res !== w.page) begin
            $display("%0t: op %s mismatch, expected status %0d page %0d, got status %0d page %0d",
                     $time, w.op.name(), w.status, w.page, rsp.status, rsp.page_res);
            errors++;
          end
          if (w.op == OP_ALLOC && w.status == ST_OK) begin
            n_ok_alloc++;
            blk.page  = w.page;
            blk.order = w.order;
            live_q.push_back(blk);
          end
          if (w.status == ST_NOMEM) n_nomem++;
          if (w.status == ST_BAD) n_bad++;
        end
      end
      if (rsp_gap > 0) begin
        rsp_gap   <= rsp_gap - 1;
        rsp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        rsp_gap   <= $urandom_range(1, 18);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    int     idx, sel, pg, cnt;
    block_t blk;
    errors = 0;
    n_ok_alloc = 0;
    n_nomem = 0;
    n_bad = 0;
    n_beats = 0;
    calm = 1'b0;
    for (int k = 0; k <= EFF_TOP; k++) begin
      free_cnt[k] = 0;
      for (int i = 0; i < NPAGES; i++) free_bit[k][i] = 1'b0;
    end
    rst       = 1'b1;
    req.valid = 1'b0;
    req.op    = OP_ALLOC;
    req.order = '0;
    req.page  = '0;
    req.count = '0;
    rsp.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_req(OP_ALLOC, 0, 0, 0);
    push_req(OP_ADD, 0, 0, 4096);
    push_req(OP_ALLOC, 10, 0, 0);
    push_req(OP_ALLOC, 0, 4095, 8191);
    push_req(OP_ALLOC, 3, 0, 0);
    push_req(OP_ALLOC, 15, 0, 0);
    push_req(OP_FREE, 3, 5, 0);
    push_req(OP_FREE, 11, 0, 0);
    push_req(OP_FREE, 0, 4095, 0);
    push_req(OP_ADD, 0, 4000, 200);
    push_req(OP_ADD, 0, 10, 0);
    push_req(OP_RESERVE, 0, 4095, 1);
    push_req(OP_RESERVE, 0, 100, 300);
    push_req(OP_RESERVE, 0, 0, 0);
    drain();
    while (live_q.size() != 0) begin
      blk = live_q.pop_front();
      push_req(OP_FREE, blk.order, blk.page, 0);
    end
    push_req(OP_RESERVE, 0, 0, 4096);
    push_req(OP_ALLOC, 0, 0, 0);
    push_req(OP_ADD, 0, 0, 4096);
    push_req(OP_FREE, 0, 0, 0);
    push_req(OP_RESERVE, 7, 3000, 5000);

    for (int n = 0; n < 1900; n++) begin
      if (n > 1700) calm = 1'b1;
      if (n % 400 == 399) begin
        // hold until the block is empty, then start from a full map
        drain();
        live_q.delete();
        push_req(OP_RESERVE, 0, 0, 4096);
        push_req(OP_ADD, 0, 0, 4096);
      end
      while (pend_q.size() > 2) @(posedge clk);
      sel = $urandom_range(0, 99);
      if (sel < 38) begin
        push_req(OP_ALLOC, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10)
                                                       : $urandom_range(0, 3), 0, 0);
      end else if (sel < 68 && live_q.size() != 0) begin
        idx = $urandom_range(0, live_q.size() - 1);
        blk = live_q[idx];
        live_q.delete(idx);
        push_req(OP_FREE, blk.order, blk.page, 0);
      end else if (sel < 78) begin
        pg  = $urandom_range(0, 4095);
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4096) : $urandom_range(1, 64);
        push_req(OP_RESERVE, 0, pg, cnt);
      end else if (sel < 88) begin
        pg  = $urandom_range(0, 4095);
        cnt = $urandom_range(0, 40);
        push_req(OP_ADD, 0, pg, cnt);
      end else begin
        push_req(op_t'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 4095),
                 $urandom_range(0, 8191));
      end
    end
    drain();
    repeat (500) @(posedge clk);
    $display("Covered %0d responses: %0d allocations granted, %0d out of memory, %0d rejected.",
             n_beats, n_ok_alloc, n_nomem, n_bad);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Timeout with %0d requests pending and %0d responses outstanding",
             pend_q.size(), want_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: buddy_page_allocator_top.f
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_req_if.sv
hw/rtl/bpa_rsp_if.sv
hw/rtl/bpa_map.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/buddy_page_allocator_top.sv
dv/buddy_page_allocator_top_test.sv
